// ----- hw/rtl/nearest_neighbor_resize_defines.svh -----
// Assertion macros used by the resize block's command queue (nnr_fifo.sv)
`ifndef NEAREST_NEIGHBOR_RESIZE_DEFINES_SVH
`define NEAREST_NEIGHBOR_RESIZE_DEFINES_SVH

// same-cycle implication, clocked on clk_i, off while rst_ni is low
`define NNR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off while rst_ni is low
`define NNR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/nnr_pkg.sv -----
// Types and constants of the nearest-neighbour resize block
`default_nettype none

package nnr_pkg;

  localparam int unsigned IN_DIM_W   = 9;
  localparam int unsigned OUT_DIM_W  = 12;
  localparam int unsigned RATIO_W    = 24;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned TOTAL_W    = 2 * IN_DIM_W;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = RATIO_W;
  localparam int unsigned DIM_MAX    = (1 << IN_DIM_W) - 1;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [CFG_IDX_W-1:0] REG_IN_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IN_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INV_RATIO  = 3'd4;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EMIT = 1'b1;

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_READ,
    CMD_EARLY
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e kind;
    logic      last;
  } cmd_ctrl_t;

  typedef struct packed {
    logic [IN_DIM_W-1:0]  in_width;
    logic [IN_DIM_W-1:0]  in_height;
    logic [OUT_DIM_W-1:0] out_width;
    logic [OUT_DIM_W-1:0] out_height;
    logic [RATIO_W-1:0]   inv_ratio;
  } cfg_t;

endpackage

`default_nettype wire

// ----- hw/rtl/nnr_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read
`default_nettype none

module nnr_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 65536,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/nnr_front.sv -----
// Front end: takes words, tracks load and output positions, builds store commands
`default_nettype none

module nnr_front #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256,
  parameter int unsigned PIXEL_BITS = 16,
  localparam int unsigned DEPTH  = MAX_WIDTH * MAX_HEIGHT,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire nnr_pkg::cfg_t         cfg_i,
  input  wire logic                  start_i,
  input  wire logic                  op_i,
  input  wire logic [PIXEL_BITS-1:0] pixel_in_i,
  output logic                       busy_o,
  input  wire logic                  q_full_i,
  output logic                       push_o,
  output nnr_pkg::cmd_ctrl_t         cmd_o,
  output logic      [ADDR_W-1:0]     addr_o,
  output logic      [PIXEL_BITS-1:0] data_o
);

  import nnr_pkg::*;

  localparam int unsigned PTR_W   = (ADDR_W + 1 > TOTAL_W) ? ADDR_W + 1 : TOTAL_W;
  localparam int unsigned PROD_W  = OUT_DIM_W + RATIO_W;
  localparam int unsigned COORD_W = PROD_W - FRAC_W;

  localparam logic [IN_DIM_W-1:0] W_TOP =
    (MAX_WIDTH > DIM_MAX) ? IN_DIM_W'(DIM_MAX) : IN_DIM_W'(MAX_WIDTH);
  localparam logic [IN_DIM_W-1:0] H_TOP =
    (MAX_HEIGHT > DIM_MAX) ? IN_DIM_W'(DIM_MAX) : IN_DIM_W'(MAX_HEIGHT);
  localparam logic [PTR_W-1:0] DEPTH_P = PTR_W'(DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ROW  = 2'd1;
  localparam logic [1:0] S_COL  = 2'd2;
  localparam logic [1:0] S_ADDR = 2'd3;

  logic [1:0]           state_q, state_d;
  logic [PTR_W-1:0]     ptr_q, ptr_d;
  logic [OUT_DIM_W-1:0] row_q, row_d;
  logic [OUT_DIM_W-1:0] col_q, col_d;
  logic [IN_DIM_W-1:0]  src_row_q, src_row_d;
  logic [IN_DIM_W-1:0]  src_col_q, src_col_d;

  logic [IN_DIM_W-1:0]  w, h, lim, lim_m1, coord_cl;
  logic [OUT_DIM_W-1:0] ow, oh, pos;
  logic [TOTAL_W-1:0]   total;
  logic [PTR_W-1:0]     total_x, addr_full;
  logic [PROD_W-1:0]    prod;
  logic [COORD_W-1:0]   coord;
  logic                 accept, can_load, frame_ready, row_end, is_last;

  // sizes with out-of-range values saturated
  always_comb begin
    priority if (cfg_i.in_width == '0) begin
      w = IN_DIM_W'(1);
    end else if (cfg_i.in_width > W_TOP) begin
      w = W_TOP;
    end else begin
      w = cfg_i.in_width;
    end
    priority if (cfg_i.in_height == '0) begin
      h = IN_DIM_W'(1);
    end else if (cfg_i.in_height > H_TOP) begin
      h = H_TOP;
    end else begin
      h = cfg_i.in_height;
    end
  end

  assign ow = (cfg_i.out_width == '0) ? OUT_DIM_W'(1) : cfg_i.out_width;
  assign oh = (cfg_i.out_height == '0) ? OUT_DIM_W'(1) : cfg_i.out_height;

  assign total       = TOTAL_W'(w) * TOTAL_W'(h);
  assign total_x     = PTR_W'(total);
  assign can_load    = (ptr_q < total_x) && (ptr_q < DEPTH_P);
  assign frame_ready = (ptr_q >= total_x);

  assign row_end = ({1'b0, col_q} + 1'b1) >= {1'b0, ow};
  assign is_last = row_end && (({1'b0, row_q} + 1'b1) >= {1'b0, oh});

  // shared coordinate multiplier: row pass, then column pass
  assign pos      = (state_q == S_ROW) ? row_q : col_q;
  assign lim      = (state_q == S_ROW) ? h : w;
  assign lim_m1   = lim - 1'b1;
  assign prod     = PROD_W'(pos) * PROD_W'(cfg_i.inv_ratio);
  assign coord    = prod[PROD_W-1:FRAC_W];
  assign coord_cl = (coord > COORD_W'(lim_m1)) ? lim_m1 : coord[IN_DIM_W-1:0];

  assign addr_full = PTR_W'(TOTAL_W'(src_row_q) * TOTAL_W'(w)) + PTR_W'(src_col_q);

  assign busy_o = (state_q != S_IDLE) || q_full_i;
  assign accept = start_i && !busy_o;

  always_comb begin
    state_d    = state_q;
    ptr_d      = ptr_q;
    row_d      = row_q;
    col_d      = col_q;
    src_row_d  = src_row_q;
    src_col_d  = src_col_q;
    push_o     = 1'b0;
    cmd_o.kind = CMD_WRITE;
    cmd_o.last = 1'b0;
    addr_o     = ptr_q[ADDR_W-1:0];
    data_o     = pixel_in_i;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (op_i == OP_LOAD) begin
            if (can_load) begin
              push_o = 1'b1;
              ptr_d  = ptr_q + 1'b1;
            end
          end else if (!frame_ready) begin
            push_o     = 1'b1;
            cmd_o.kind = CMD_EARLY;
          end else begin
            state_d = S_ROW;
          end
        end
      end
      S_ROW: begin
        src_row_d = coord_cl;
        state_d   = S_COL;
      end
      S_COL: begin
        src_col_d = coord_cl;
        state_d   = S_ADDR;
      end
      S_ADDR: begin
        addr_o     = addr_full[ADDR_W-1:0];
        cmd_o.kind = CMD_READ;
        cmd_o.last = is_last;
        if (!q_full_i) begin
          push_o  = 1'b1;
          state_d = S_IDLE;
          if (is_last) begin
            ptr_d = '0;
            row_d = '0;
            col_d = '0;
          end else if (row_end) begin
            col_d = '0;
            row_d = row_q + 1'b1;
          end else begin
            col_d = col_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ptr_q   <= '0;
      row_q   <= '0;
      col_q   <= '0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      row_q   <= row_d;
      col_q   <= col_d;
    end
  end

  always_ff @(posedge clk_i) begin
    src_row_q <= src_row_d;
    src_col_q <= src_col_d;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/nnr_fifo.sv -----
// Short command queue between front end and back end
`default_nettype none

`include "nearest_neighbor_resize_defines.svh"

module nnr_fifo #(
  parameter int unsigned ADDR_W     = 16,
  parameter int unsigned PIXEL_BITS = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  input  wire nnr_pkg::cmd_ctrl_t    cmd_i,
  input  wire logic [ADDR_W-1:0]     addr_i,
  input  wire logic [PIXEL_BITS-1:0] data_i,
  output logic                       full_o,
  output logic                       empty_o,
  input  wire logic                  pop_i,
  output nnr_pkg::cmd_ctrl_t         cmd_o,
  output logic      [ADDR_W-1:0]     addr_o,
  output logic      [PIXEL_BITS-1:0] data_o
);

  import nnr_pkg::*;

  cmd_ctrl_t             cmd_q  [QUEUE_DEPTH];
  logic [ADDR_W-1:0]     addr_q [QUEUE_DEPTH];
  logic [PIXEL_BITS-1:0] data_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]     wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]       count_q;

  assign full_o  = (count_q == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign cmd_o   = cmd_q[rd_ptr_q];
  assign addr_o  = addr_q[rd_ptr_q];
  assign data_o  = data_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      cmd_q[wr_ptr_q]  <= cmd_i;
      addr_q[wr_ptr_q] <= addr_i;
      data_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  `NNR_ASSERT_IMP(a_no_overflow, push_i, !full_o, "command pushed into full queue")
  `NNR_ASSERT_IMP(a_no_underflow, pop_i, !empty_o, "command popped from empty queue")
  `NNR_ASSERT_NXT(a_count_up, push_i && !pop_i, count_q == $past(count_q) + 1'b1, "queue count lost a word")

endmodule

`default_nettype wire

// ----- hw/rtl/nnr_back.sv -----
// Back end: executes store commands and drives the result word
`default_nettype none

module nnr_back #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256,
  parameter int unsigned PIXEL_BITS = 16,
  localparam int unsigned DEPTH  = MAX_WIDTH * MAX_HEIGHT,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  empty_i,
  input  wire nnr_pkg::cmd_ctrl_t    cmd_i,
  input  wire logic [ADDR_W-1:0]     addr_i,
  input  wire logic [PIXEL_BITS-1:0] data_i,
  output logic                       pop_o,
  output logic                       done_o,
  output logic      [PIXEL_BITS-1:0] pixel_o,
  output logic                       ready_res_o,
  output logic                       last_o
);

  import nnr_pkg::*;

  logic                  we, re, res_v_d, res_ok_d;
  logic                  res_v_q, res_ok_q, res_last_q;
  logic [PIXEL_BITS-1:0] rdata;

  assign pop_o = !empty_i;

  always_comb begin
    we       = 1'b0;
    re       = 1'b0;
    res_v_d  = 1'b0;
    res_ok_d = 1'b0;
    unique case (cmd_i.kind)
      CMD_WRITE: begin
        we = pop_o;
      end
      CMD_READ: begin
        re       = pop_o;
        res_v_d  = pop_o;
        res_ok_d = 1'b1;
      end
      CMD_EARLY: begin
        res_v_d = pop_o;
      end
      default: begin
        res_v_d = 1'b0;
      end
    endcase
  end

  nnr_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (addr_i),
    .wdata_i (data_i),
    .re_i    (re),
    .raddr_i (addr_i),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_v_q    <= 1'b0;
      res_ok_q   <= 1'b0;
      res_last_q <= 1'b0;
    end else begin
      res_v_q <= res_v_d;
      if (pop_o) begin
        res_ok_q   <= res_ok_d;
        res_last_q <= res_ok_d && cmd_i.last;
      end
    end
  end

  assign done_o      = res_v_q;
  assign ready_res_o = res_ok_q;
  assign last_o      = res_last_q;
  assign pixel_o     = res_ok_q ? rdata : '0;

endmodule

`default_nettype wire

// ----- hw/rtl/nearest_neighbor_resize.sv -----
// Top level of the nearest-neighbour resize block
//
// Usage: a word is taken on a rising edge with start_i high and busy_o low.
// op_i low loads pixel_in_i as the next source pixel in raster order; op_i
// high asks for the next resized pixel in raster order. Each emit word gives
// one result, shown on pixel_out_o, ready_res_o and last_o for the single
// cycle in which done_o is high; load words give none. ready_res_o low means
// the frame was not fully loaded and nothing advanced. last_o marks the final
// pixel of the resized plane, after which the frame must be loaded again.
// Registers are written through cfg_we_i, cfg_idx_i and cfg_data_i; the user
// must do so only while idle, as the block does not enforce it. Rate: loads
// are taken one per cycle while busy_o is low. An emit occupies the front end
// through its row, column and address states, as the row and column
// coordinates pass one after the other through a single 12x24 multiplier
// before the address multiply-add. Every command, also a load or an early
// emit, passes through the command queue; the frame store read is registered.
// Reset clears positions, load count and registers to their defaults; the
// frame store is not cleared. The receiver cannot stall results.
`default_nettype none

module nearest_neighbor_resize #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256,
  parameter int unsigned PIXEL_BITS = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  output logic                                busy_o,
  input  wire logic                           op_i,
  input  wire logic signed [PIXEL_BITS-1:0]   pixel_in_i,
  input  wire logic                           cfg_we_i,
  input  wire logic [nnr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [nnr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic                                done_o,
  output logic signed      [PIXEL_BITS-1:0]   pixel_out_o,
  output logic                                ready_res_o,
  output logic                                last_o
);

  import nnr_pkg::*;

  localparam int unsigned DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cfg_t                  cfg_q;
  logic                  q_full, q_empty, push, pop;
  cmd_ctrl_t             push_cmd, head_cmd;
  logic [ADDR_W-1:0]     push_addr, head_addr;
  logic [PIXEL_BITS-1:0] push_data, head_data, pixel_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.in_width   <= IN_DIM_W'(256);
      cfg_q.in_height  <= IN_DIM_W'(256);
      cfg_q.out_width  <= OUT_DIM_W'(256);
      cfg_q.out_height <= OUT_DIM_W'(256);
      cfg_q.inv_ratio  <= RATIO_W'(65536);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_IN_WIDTH:   cfg_q.in_width   <= cfg_data_i[IN_DIM_W-1:0];
        REG_IN_HEIGHT:  cfg_q.in_height  <= cfg_data_i[IN_DIM_W-1:0];
        REG_OUT_WIDTH:  cfg_q.out_width  <= cfg_data_i[OUT_DIM_W-1:0];
        REG_OUT_HEIGHT: cfg_q.out_height <= cfg_data_i[OUT_DIM_W-1:0];
        REG_INV_RATIO:  cfg_q.inv_ratio  <= cfg_data_i[RATIO_W-1:0];
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  nnr_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .start_i    (start_i),
    .op_i       (op_i),
    .pixel_in_i (pixel_in_i),
    .busy_o     (busy_o),
    .q_full_i   (q_full),
    .push_o     (push),
    .cmd_o      (push_cmd),
    .addr_o     (push_addr),
    .data_o     (push_data)
  );

  nnr_fifo #(
    .ADDR_W     (ADDR_W),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .addr_i  (push_addr),
    .data_i  (push_data),
    .full_o  (q_full),
    .empty_o (q_empty),
    .pop_i   (pop),
    .cmd_o   (head_cmd),
    .addr_o  (head_addr),
    .data_o  (head_data)
  );

  nnr_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .cmd_i       (head_cmd),
    .addr_i      (head_addr),
    .data_i      (head_data),
    .pop_o       (pop),
    .done_o      (done_o),
    .pixel_o     (pixel_out),
    .ready_res_o (ready_res_o),
    .last_o      (last_o)
  );

  assign pixel_out_o = pixel_out;

endmodule

`default_nettype wire
